/* hdl/agcjg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard package
// Shared types, register indexes and reset constants for the jump guard.
// ----------------------------------------------------------------------------
package agcjg_pkg;

    // Field widths of one polling tick and of the registers.
    localparam int FREQ_W  = 32;
    localparam int LEVEL_W = 10;
    localparam int GAIN_W  = 8;
    localparam int HOLD_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] LEVEL_LIMIT_RST = 10'd12;
    localparam logic [GAIN_W-1:0]  GAIN_LIMIT_RST  = 8'd8;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 8'd30;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_LIMIT = 2'd0,
        CFG_GAIN_LIMIT  = 2'd1,
        CFG_HOLD_TICKS  = 2'd2
    } t_cfg_idx;

    // Requested action toward the gain control.
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_DISABLE = 2'd1,
        ACT_ENABLE  = 2'd2
    } t_action;

    // Register contents seen by the guard logic.
    typedef struct packed {
        logic [LEVEL_W-1:0] level_limit;
        logic [GAIN_W-1:0]  gain_limit;
        logic [HOLD_W-1:0]  hold_ticks;
    } t_cfg;

    // One polling tick.
    typedef struct packed {
        logic                      rx_active;
        logic [FREQ_W-1:0]         frequency;
        logic signed [LEVEL_W-1:0] level_dbm;
        logic signed [GAIN_W-1:0]  gain_db;
    } t_tick;

endpackage

/* hdl/agcjg_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard configuration registers
// Holds the trip limits and the hold length, written over a valid/ready port.
// ----------------------------------------------------------------------------
module agcjg_cfg_regs
    import agcjg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Decode the written register; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEVEL_LIMIT: n_cfg.level_limit = i_cfg_data[LEVEL_W-1:0];
                CFG_GAIN_LIMIT:  n_cfg.gain_limit  = i_cfg_data[GAIN_W-1:0];
                CFG_HOLD_TICKS:  n_cfg.hold_ticks  = i_cfg_data[HOLD_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_limit <= LEVEL_LIMIT_RST;
            r_cfg.gain_limit  <= GAIN_LIMIT_RST;
            r_cfg.hold_ticks  <= HOLD_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/agcjg_guard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard decision stage
// Keeps the last sample and the hold count, and decides the action of a tick.
// ----------------------------------------------------------------------------
module agcjg_guard
    import agcjg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_tick   i_tick,
    input  t_cfg    i_cfg,
    output t_action o_action
);

    logic [FREQ_W-1:0]         r_last_freq;
    logic signed [LEVEL_W-1:0] r_last_level;
    logic signed [GAIN_W-1:0]  r_last_gain;
    logic [HOLD_W-1:0]         r_hold;
    logic                      r_sample_valid;

    logic [FREQ_W-1:0]         n_last_freq;
    logic signed [LEVEL_W-1:0] n_last_level;
    logic signed [GAIN_W-1:0]  n_last_gain;
    logic [HOLD_W-1:0]         n_hold;
    logic                      n_sample_valid;

    logic                      freq_change;
    logic                      eff_valid;
    logic [HOLD_W-1:0]         eff_hold;
    logic signed [LEVEL_W:0]   level_diff;
    logic signed [GAIN_W:0]    gain_diff;
    logic [LEVEL_W:0]          level_mag;
    logic [GAIN_W:0]           gain_mag;
    logic                      trip;

    // Full-width differences, so a jump never wraps.
    always_comb begin
        level_diff = {i_tick.level_dbm[LEVEL_W-1], i_tick.level_dbm}
                   - {r_last_level[LEVEL_W-1], r_last_level};
        gain_diff  = {i_tick.gain_db[GAIN_W-1], i_tick.gain_db}
                   - {r_last_gain[GAIN_W-1], r_last_gain};
        level_mag  = level_diff[LEVEL_W] ? (LEVEL_W+1)'(-level_diff)
                                         : (LEVEL_W+1)'(level_diff);
        gain_mag   = gain_diff[GAIN_W] ? (GAIN_W+1)'(-gain_diff)
                                       : (GAIN_W+1)'(gain_diff);
        trip = (level_mag >= {1'b0, i_cfg.level_limit})
            || (gain_mag >= {1'b0, i_cfg.gain_limit});
    end

    // A new frequency abandons the hold and the sample on the same tick.
    assign freq_change = (i_tick.frequency != r_last_freq);
    assign eff_valid   = r_sample_valid && !freq_change;
    assign eff_hold    = freq_change ? '0 : r_hold;

    // Next state and action of one tick.
    always_comb begin
        n_last_freq    = r_last_freq;
        n_last_level   = r_last_level;
        n_last_gain    = r_last_gain;
        n_hold         = r_hold;
        n_sample_valid = r_sample_valid;
        o_action       = ACT_NONE;
        if (!i_tick.rx_active) begin
            n_hold         = '0;
            n_sample_valid = 1'b0;
        end else begin
            n_last_freq    = i_tick.frequency;
            n_last_level   = i_tick.level_dbm;
            n_last_gain    = i_tick.gain_db;
            n_sample_valid = 1'b1;
            n_hold         = eff_hold;
            priority if (!eff_valid) begin
                n_hold = eff_hold;
            end else if (eff_hold != '0) begin
                n_hold = eff_hold - 1'b1;
                if (eff_hold == HOLD_W'(1)) begin
                    o_action = ACT_ENABLE;
                end
            end else begin
                if (trip) begin
                    o_action = ACT_DISABLE;
                    n_hold   = i_cfg.hold_ticks;
                end
            end
        end
    end

    // State advances only when a tick moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_freq    <= '0;
            r_last_level   <= '0;
            r_last_gain    <= '0;
            r_hold         <= '0;
            r_sample_valid <= 1'b0;
        end else if (i_step) begin
            r_last_freq    <= n_last_freq;
            r_last_level   <= n_last_level;
            r_last_gain    <= n_last_gain;
            r_hold         <= n_hold;
            r_sample_valid <= n_sample_valid;
        end
    end

endmodule

/* hdl/agc_jump_guard_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard core
// Disables a receiver's gain control on level or gain jumps and re-enables it
// after a hold of a set number of polling ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one polling tick per
//   transaction: active flag, tuned frequency, level in dBm and gain in dB.
//   Output channel (o_out_valid / i_out_ready) returns exactly one action per
//   tick, in order: none, disable or re-enable gain control.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the level limit,
//   the gain limit and the hold length; it is always ready and should only be
//   used while no tick is in flight.
//   An accepted tick passes through the input register, then the decision
//   logic loads the result register, where its action becomes valid.
//   Throughput is one tick per cycle while the receiver keeps up.
//   A synchronous active-low reset restores the register defaults, clears
//   the stored sample and hold count and empties both stages.
//   When the receiver stalls, the result register holds its action and the
//   input register still takes one more tick before o_in_ready drops.
// ----------------------------------------------------------------------------
module agc_jump_guard_core
    import agcjg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_rx_active,
    input  logic [FREQ_W-1:0]         i_frequency,
    input  logic signed [LEVEL_W-1:0] i_level_dbm,
    input  logic signed [GAIN_W-1:0]  i_gain_db,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_agc_action,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_tick   r_in;
    logic    r_in_valid;
    logic    r_out_valid;
    t_action r_out_action;
    t_action calc_action;
    logic    advance;

    // Configuration registers.
    agcjg_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // A tick moves on when the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.rx_active <= i_rx_active;
            r_in.frequency <= i_frequency;
            r_in.level_dbm <= i_level_dbm;
            r_in.gain_db   <= i_gain_db;
        end
    end

    // Decision logic and guard state.
    agcjg_guard u_guard (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_tick   (r_in),
        .i_cfg    (cfg),
        .o_action (calc_action)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_action <= calc_action;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_agc_action = r_out_action;

`ifndef SYNTH
    // An inactive tick always answers with no change.
    a_inactive_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in.rx_active) |=> (r_out_action == ACT_NONE))
        else $error("inactive tick produced an action");

    // Input back-pressure only when both stages are full and stalled.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    // A stalled result is neither lost nor changed.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_action)))
        else $error("stalled result lost or changed");
`endif

endmodule

/* tb/sv/agc_guard_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard checker
// Watches the tick, action and register channels of the jump guard, predicts
// the action for every accepted tick and compares it with the action that
// comes back. Reports the number of mismatches and the actions still owed.
// ----------------------------------------------------------------------------
module agc_guard_checker
    import agcjg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_rx_active,
    input  logic [FREQ_W-1:0]         i_frequency,
    input  logic signed [LEVEL_W-1:0] i_level_dbm,
    input  logic signed [GAIN_W-1:0]  i_gain_db,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [1:0]                i_agc_action,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    // Register copies.
    logic [LEVEL_W-1:0] lim_level;
    logic [GAIN_W-1:0]  lim_gain;
    logic [HOLD_W-1:0]  hold_len;

    // Guard state copies.
    logic [FREQ_W-1:0]         seen_freq;
    logic signed [LEVEL_W-1:0] seen_level;
    logic signed [GAIN_W-1:0]  seen_gain;
    logic [HOLD_W-1:0]         hold_left;
    logic                      have_sample;

    // Actions owed by the block, oldest first.
    t_action owed_actions[$];

    t_tick tick_in;
    assign tick_in = {i_rx_active, i_frequency, i_level_dbm, i_gain_db};

    // Works out the action for one tick and advances the guard state.
    function automatic t_action guard_decide(input t_tick tk);
        int      level_step;
        int      gain_step;
        t_action act;
        act = ACT_NONE;
        if (!tk.rx_active) begin
            hold_left   = '0;
            have_sample = 1'b0;
            return ACT_NONE;
        end
        // A retune abandons the hold and the sample on the same tick.
        if (tk.frequency != seen_freq) begin
            seen_freq   = tk.frequency;
            hold_left   = '0;
            have_sample = 1'b0;
        end
        if (!have_sample) begin
            have_sample = 1'b1;
        end else if (hold_left != '0) begin
            hold_left = hold_left - 1'b1;
            if (hold_left == '0) begin
                act = ACT_ENABLE;
            end
        end else begin
            // Differences are taken at integer width, so they never wrap.
            level_step = int'($signed(tk.level_dbm)) - int'(seen_level);
            gain_step  = int'($signed(tk.gain_db)) - int'(seen_gain);
            if (level_step < 0) level_step = -level_step;
            if (gain_step < 0) gain_step = -gain_step;
            if (level_step >= int'(lim_level) || gain_step >= int'(lim_gain)) begin
                act       = ACT_DISABLE;
                hold_left = hold_len;
            end
        end
        seen_level = tk.level_dbm;
        seen_gain  = tk.gain_db;
        return act;
    endfunction

    // Track register writes, check returned actions, queue new predictions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lim_level   = LEVEL_LIMIT_RST;
            lim_gain    = GAIN_LIMIT_RST;
            hold_len    = HOLD_TICKS_RST;
            seen_freq   = '0;
            seen_level  = '0;
            seen_gain   = '0;
            hold_left   = '0;
            have_sample = 1'b0;
            owed_actions.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LEVEL_LIMIT: lim_level = i_cfg_data[LEVEL_W-1:0];
                    CFG_GAIN_LIMIT:  lim_gain  = i_cfg_data[GAIN_W-1:0];
                    CFG_HOLD_TICKS:  hold_len  = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            // A returned action always belongs to an older tick than one
            // accepted at the same edge, so compare before queuing.
            if (i_out_valid && i_out_ready) begin
                if (owed_actions.size() == 0) begin
                    $error("agc_action: unexpected transaction, actual %0d", i_agc_action);
                    o_fail_count++;
                end else if (i_agc_action !== owed_actions[0]) begin
                    $error("agc_action: expected %0d, actual %0d",
                           owed_actions[0], i_agc_action);
                    o_fail_count++;
                    void'(owed_actions.pop_front());
                end else begin
                    void'(owed_actions.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_actions.push_back(guard_decide(tick_in));
            end
            o_pending <= owed_actions.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AGC jump guard testbench
// Drives polling ticks and register writes into the jump guard with bursty
// traffic and a stalling receiver; a checker beside the block predicts and
// compares every action.
// ----------------------------------------------------------------------------
module tb;
    import agcjg_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 500;
    // Length of the one long receiver hold-off.
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_TICKS = 165;
    // Register index that no register answers to.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_rx_active;
    logic [FREQ_W-1:0]         i_frequency;
    logic signed [LEVEL_W-1:0] i_level_dbm;
    logic signed [GAIN_W-1:0]  i_gain_db;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [1:0]                o_agc_action;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;
    int burst_left;
    int cur_level;
    int cur_gain;
    logic [FREQ_W-1:0] cur_freq;
    bit hold_off_req;
    bit hold_off_done;

    agc_jump_guard_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_active  (i_rx_active),
        .i_frequency  (i_frequency),
        .i_level_dbm  (i_level_dbm),
        .i_gain_db    (i_gain_db),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_agc_action (o_agc_action),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    agc_guard_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_rx_active  (i_rx_active),
        .i_frequency  (i_frequency),
        .i_level_dbm  (i_level_dbm),
        .i_gain_db    (i_gain_db),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_agc_action (o_agc_action),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog on cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: stretches of different stall patterns, plus one long hold-off.
    initial begin
        int mode;
        int span;
        i_out_ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_off_req && !hold_off_done) begin
                    i_out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                    hold_off_done = 1'b1;
                end else begin
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= ($urandom_range(0, 1) == 0);
                        2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                        default: i_out_ready <= ~i_out_ready;
                    endcase
                end
            end
        end
    end

    // Offers one tick, with random gaps between bursts, until it is taken.
    task automatic send_tick(input logic act, input logic [FREQ_W-1:0] freq,
                             input int level, input int gain);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_rx_active <= act;
        i_frequency <= freq;
        i_level_dbm <= LEVEL_W'(level);
        i_gain_db   <= GAIN_W'(gain);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Writes one register; the caller lowers valid after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Unused upper data bits of the narrow registers carry random noise.
    task automatic set_limits(input int level_lim, input int gain_lim, input int hold);
        write_reg(CFG_LEVEL_LIMIT, CFG_DATA_W'(level_lim));
        write_reg(CFG_GAIN_LIMIT, {2'($urandom), GAIN_W'(gain_lim)});
        write_reg(CFG_HOLD_TICKS, {2'($urandom), HOLD_W'(hold)});
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering ticks and waits until every action has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly one station with small drifts, some jumps, retunes and dropouts.
    task automatic random_tick();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            send_tick(1'b0, $urandom(), int'($urandom_range(0, 1023)) - 512,
                      int'($urandom_range(0, 255)) - 128);
        end else begin
            if (pick < 10) begin
                cur_freq = $urandom();
            end else if (pick < 25) begin
                case ($urandom_range(0, 2))
                    0:       cur_level = -512;
                    1:       cur_level = 511;
                    default: cur_level = int'($urandom_range(0, 1023)) - 512;
                endcase
                case ($urandom_range(0, 2))
                    0:       cur_gain = -128;
                    1:       cur_gain = 127;
                    default: cur_gain = int'($urandom_range(0, 255)) - 128;
                endcase
            end else begin
                cur_level += int'($urandom_range(0, 48)) - 24;
                cur_gain  += int'($urandom_range(0, 24)) - 12;
                if (cur_level > 511) cur_level = 511;
                if (cur_level < -512) cur_level = -512;
                if (cur_gain > 127) cur_gain = 127;
                if (cur_gain < -128) cur_gain = -128;
            end
            send_tick(1'b1, cur_freq, cur_level, cur_gain);
        end
    endtask

    // Main sequence: reset, directed ticks, then random phases.
    initial begin
        int lvl_lim;
        int gain_lim;
        int hold;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_active <= 1'b0;
        i_frequency <= '0;
        i_level_dbm <= '0;
        i_gain_db   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_LEVEL_LIMIT;
        i_cfg_data  <= '0;
        idle_cycles = 0;
        burst_left  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short hold so the directed ticks see a full trip and re-enable.
        write_reg(CFG_HOLD_TICKS, 10'h302);
        i_cfg_valid <= 1'b0;

        // Inactive tick, then full-width level and gain swings.
        send_tick(1'b0, 32'h1234_5678, -512, -128);
        send_tick(1'b1, 32'h0000_0000, 511, 127);
        send_tick(1'b1, 32'h0000_0000, -512, 127);
        send_tick(1'b1, 32'h0000_0000, -512, 127);
        send_tick(1'b1, 32'h0000_0000, -512, 127);
        send_tick(1'b1, 32'h0000_0000, -512, -128);
        // Inactivity drops the sample but keeps the frequency.
        send_tick(1'b0, 32'h0000_0000, 0, 0);
        send_tick(1'b1, 32'h0000_0000, 100, 10);
        // Just below both limits, then exactly at the level limit.
        send_tick(1'b1, 32'h0000_0000, 111, 17);
        send_tick(1'b1, 32'h0000_0000, 123, 17);
        // Retune during a hold only stores a sample.
        send_tick(1'b1, 32'hFFFF_FFFF, 123, 17);
        send_tick(1'b1, 32'hFFFF_FFFF, 123, 25);
        send_tick(1'b1, 32'hFFFF_FFFF, 0, 0);
        send_tick(1'b0, 32'h0000_0000, 0, 0);
        send_tick(1'b1, 32'hFFFF_FFFF, -1, -1);
        send_tick(1'b1, 32'hFFFF_FFFF, -1, -1);
        drain();

        // Zero limits trip on every compare; zero hold starts no hold.
        write_reg(CFG_SPARE_IDX, 10'h3FF);
        set_limits(0, 0, 0);
        send_tick(1'b1, 32'hFFFF_FFFF, -1, -1);
        send_tick(1'b1, 32'hFFFF_FFFF, -1, -1);
        send_tick(1'b1, 32'hFFFF_FFFF, 5, 3);
        send_tick(1'b1, 32'h5555_AAAA, 0, 0);
        drain();

        // Random phases over several register settings.
        cur_freq  = $urandom();
        cur_level = 0;
        cur_gain  = 0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin lvl_lim = 12;   gain_lim = 8;   hold = 30;  end
                1: begin lvl_lim = 1023; gain_lim = 255; hold = 255; end
                2: begin lvl_lim = 0;    gain_lim = 0;   hold = 1;   end
                3: begin lvl_lim = 40;   gain_lim = 20;  hold = 0;   end
                4: begin
                    lvl_lim  = $urandom_range(0, 1023);
                    gain_lim = $urandom_range(0, 255);
                    hold     = $urandom_range(1, 8);
                end
                default: begin lvl_lim = 5; gain_lim = 3; hold = 4; end
            endcase
            set_limits(lvl_lim, gain_lim, hold);
            // Back up the block once with a long receiver hold-off.
            if (p == 0) hold_off_req = 1'b1;
            repeat (PHASE_TICKS) random_tick();
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
